// ===== rtl/moment_orientation_interaction_row_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the orientation interaction row unit
// Implication and next-cycle implication checks, clocked, with reset disable.
// ---------------------------------------------------------------------------
`ifndef MOMENT_ORIENTATION_INTERACTION_ROW_UNIT_MACROS_SVH
`define MOMENT_ORIENTATION_INTERACTION_ROW_UNIT_MACROS_SVH

// same-cycle implication
`define MIR_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("orientation row unit: property violated");

// next-cycle implication
`define MIR_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("orientation row unit: property violated");

`endif

// ===== rtl/mir_pkg.sv =====
// ---------------------------------------------------------------------------
// mir_pkg
// Shared constants, register codes and helpers of the orientation row unit.
// ---------------------------------------------------------------------------
`default_nettype none

package mir_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int IN_FRAC_DEF    = 24;
  localparam int OUT_FRAC_DEF   = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int N_IN_FIELDS    = 9;
  localparam int N_TERMS        = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_A  = 2'd0,
    REG_PLANE_B  = 2'd1,
    REG_DISCRETE = 2'd2
  } cfg_reg_t;

  function automatic int imax(input int x, input int y);
    return (x > y) ? x : y;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mir_mul.sv =====
// ---------------------------------------------------------------------------
// mir_mul
// Pipelined signed multiplier: wide operand taken one limb per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module mir_mul #(
  parameter int AW = 68,
  parameter int BW = 32,
  parameter int LW = 32
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [AW-1:0]  a,
  input  logic signed [BW-1:0]  b,
  output logic signed [AW+BW-1:0] p
);

  localparam int NL  = (AW + LW - 1) / LW;
  localparam int APW = NL * LW;
  localparam int PW  = AW + BW;

  logic signed [PW-1:0]  acc [NL];
  logic [APW-1:0]        ar  [NL-1];
  logic signed [BW-1:0]  br  [NL-1];

  function automatic logic signed [PW-1:0] part(input logic [APW-1:0] av,
                                                input logic signed [BW-1:0] bv,
                                                input int j);
    logic signed [LW:0]    limb;
    logic signed [LW+BW:0] pp;
    limb = $signed({(j == NL - 1) ? av[APW-1] : 1'b0, av[j*LW +: LW]});
    pp   = limb * bv;
    return PW'(pp) <<< (j * LW);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      acc[0] <= part(APW'(a), b, 0);
      ar[0]  <= APW'(a);
      br[0]  <= b;
      for (int j = 1; j < NL; j++) begin
        acc[j] <= acc[j-1] + part(ar[j-1], br[j-1], j);
        if (j < NL - 1) begin
          ar[j] <= ar[j-1];
          br[j] <= br[j-1];
        end
      end
    end
  end

  assign p = acc[NL-1];

endmodule

`default_nettype wire

// ===== rtl/mir_div.sv =====
// ---------------------------------------------------------------------------
// mir_div
// Pipelined signed divide with round half away from zero and saturation.
// ---------------------------------------------------------------------------
`default_nettype none

module mir_div import mir_pkg::*; #(
  parameter int NUM_W     = 128,
  parameter int DEN_W     = 66,
  parameter int NUM_SHIFT = 0,
  parameter int DEN_SHIFT = 0,
  parameter int OUT_W     = 32
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic signed [OUT_W-1:0] val,
  output logic                    sat
);

  localparam int QW  = OUT_W + 1;
  localparam int MW  = NUM_W + NUM_SHIFT;
  localparam int DDW = DEN_W + DEN_SHIFT;
  localparam int RW  = imax(MW, DDW + QW);

  logic [NUM_W-1:0] mag;
  logic [RW-1:0]    n_ext;
  logic [RW-1:0]    d_ext;
  logic             ovf_in;

  logic [RW-1:0]    rem [QW];
  logic [RW-1:0]    dv  [QW];
  logic [QW-1:0]    quo [QW+1];
  logic             ng  [QW+1];
  logic             ov  [QW+1];

  assign mag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign n_ext  = RW'(mag) << NUM_SHIFT;
  assign d_ext  = RW'(den) << DEN_SHIFT;
  // quotient would need more than QW bits
  assign ovf_in = (n_ext >> QW) >= d_ext;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= n_ext;
      dv[0]  <= d_ext;
      quo[0] <= '0;
      ng[0]  <= num[NUM_W-1];
      ov[0]  <= ovf_in;
    end
  end

  for (genvar i = 1; i <= QW; i++) begin : g_stage
    localparam int BP = QW - i;
    logic [RW-1:0] sub;
    logic          ge;

    assign sub = dv[i-1] << BP;
    assign ge  = rem[i-1] >= sub;

    always_ff @(posedge clk) begin
      if (en) begin
        quo[i] <= quo[i-1] | (ge ? (QW'(1) << BP) : QW'(0));
        ng[i]  <= ng[i-1];
        ov[i]  <= ov[i-1];
      end
    end

    if (i < QW) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i] <= ge ? rem[i-1] - sub : rem[i-1];
          dv[i]  <= dv[i-1];
        end
      end
    end
  end

  logic [QW:0]   q_inc;
  logic [QW-1:0] q_rnd;
  logic [QW-1:0] lim;
  logic [QW-1:0] mag_o;

  always_comb begin
    q_inc = {1'b0, quo[QW]} + (QW+1)'(1);
    q_rnd = q_inc[QW:1];
    lim   = QW'(1) << (OUT_W - 1);
    sat   = ov[QW] | (ng[QW] ? (q_rnd > lim) : (q_rnd > lim - QW'(1)));
    if (sat) begin
      mag_o = ng[QW] ? lim : lim - QW'(1);
    end else begin
      mag_o = q_rnd;
    end
    val = ng[QW] ? OUT_W'(-mag_o) : OUT_W'(mag_o);
  end

endmodule

`default_nettype wire

// ===== rtl/moment_orientation_interaction_row_unit.sv =====
// ---------------------------------------------------------------------------
// moment_orientation_interaction_row_unit
// L1 and L2 are the limb counts of the two wide multiplier chains.
// Throughput: one transaction per cycle while the output is not stalled; the
//   restoring divider retires one quotient bit per stage and every stage takes
//   a new item each cycle unless the output stalls.
// Reset clears the valid chain and sets plane_a = plane_b = 0, discrete mode.
// ---------------------------------------------------------------------------
`default_nettype none

`include "moment_orientation_interaction_row_unit_macros.svh"

module moment_orientation_interaction_row_unit import mir_pkg::*; #(
  parameter int DATA_WIDTH    = DATA_WIDTH_DEF,
  parameter int IN_FRAC_BITS  = IN_FRAC_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_DEF,
  localparam int IN_TDW  = ((N_IN_FIELDS * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDW = ((N_TERMS * DATA_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // mu_11, mu_20, mu_02, mu_12, mu_21, mu_03, mu_30, centroid_x, centroid_y
  input  logic [IN_TDW-1:0]     s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // row_vx, row_vy, row_vz, row_wx, row_wy
  output logic [OUT_TDW-1:0]    m_tdata,
  // degenerate, saturated
  output logic [1:0]            m_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DATA_WIDTH-1:0] cfg_data
);

  localparam int W    = DATA_WIDTH;
  localparam int F    = IN_FRAC_BITS;
  localparam int O    = OUT_FRAC_BITS;
  localparam int W1   = W + 1;
  localparam int P2   = 2 * W + 2;
  localparam int S3W  = 2 * W + 4;
  localparam int DW   = 2 * W + 2;
  localparam int G1W  = S3W + W;
  localparam int NW   = 3 * W + F + 6;
  localparam int G2W  = NW + W;
  localparam int ZW   = NW + W + 1;
  localparam int L1   = (S3W + W - 1) / W;
  localparam int L2   = (NW + W - 1) / W;
  localparam int QW   = W + 1;
  localparam int DL   = L1 + L2 + 2;
  localparam int LAT  = L1 + L2 + QW + 7;
  localparam int T_V  = O - F;
  localparam int T_Z  = O + 1 - 2 * F;
  localparam int T_W  = O + 1 - F;

  // configuration
  logic signed [W-1:0] plane_a;
  logic signed [W-1:0] plane_b;
  logic                discrete_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_a       <= '0;
      plane_b       <= '0;
      discrete_mode <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_PLANE_A:  plane_a       <= cfg_data;
        REG_PLANE_B:  plane_b       <= cfg_data;
        REG_DISCRETE: discrete_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // flow control
  logic           adv;
  logic [LAT-1:0] vld;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // input fields
  logic signed [W-1:0] mu_11, mu_20, mu_02, mu_12, mu_21, mu_03, mu_30;
  logic signed [W-1:0] centroid_x, centroid_y;

  assign mu_11      = s_tdata[0*W +: W];
  assign mu_20      = s_tdata[1*W +: W];
  assign mu_02      = s_tdata[2*W +: W];
  assign mu_12      = s_tdata[3*W +: W];
  assign mu_21      = s_tdata[4*W +: W];
  assign mu_03      = s_tdata[5*W +: W];
  assign mu_30      = s_tdata[6*W +: W];
  assign centroid_x = s_tdata[7*W +: W];
  assign centroid_y = s_tdata[8*W +: W];

  // stage 1: sums and differences
  logic signed [W1-1:0] q1, p1, dm1, dn1;
  logic signed [W-1:0]  m11_1, m20_1, m02_1, m12_1, m21_1, xg1, yg1;

  always_ff @(posedge clk) begin
    if (adv) begin
      q1    <= W1'(mu_20) - W1'(mu_02);
      p1    <= W1'(mu_20) + W1'(mu_02);
      dm1   <= W1'(mu_03) - W1'(mu_21);
      dn1   <= W1'(mu_30) - W1'(mu_12);
      m11_1 <= mu_11;
      m20_1 <= mu_20;
      m02_1 <= mu_02;
      m12_1 <= mu_12;
      m21_1 <= mu_21;
      xg1   <= centroid_x;
      yg1   <= centroid_y;
    end
  end

  // stage 2: second-order products
  logic signed [P2-1:0] qq2, mm2, m11p2, pm02_2, pp2;
  logic signed [P2-1:0] m12q2, m11dm2, m02q2, m11dn2, m21q2, m20q2;
  logic signed [W-1:0]  xg2, yg2;

  always_ff @(posedge clk) begin
    if (adv) begin
      qq2    <= P2'(q1 * q1);
      mm2    <= P2'(m11_1 * m11_1);
      m11p2  <= P2'(m11_1 * p1);
      pm02_2 <= P2'(p1 * m02_1);
      pp2    <= P2'(p1 * p1);
      m12q2  <= P2'(m12_1 * q1);
      m11dm2 <= P2'(m11_1 * dm1);
      m02q2  <= P2'(m02_1 * q1);
      m11dn2 <= P2'(m11_1 * dn1);
      m21q2  <= P2'(m21_1 * q1);
      m20q2  <= P2'(m20_1 * q1);
      xg2    <= xg1;
      yg2    <= yg1;
    end
  end

  // stage 3: sums
  logic signed [S3W-1:0] d_c, k_c, mm2x;
  logic [DW-1:0]         d3;
  logic signed [S3W-1:0] kpd3, kmd3, sw3, sy3, tx3, ty3, m11p3;
  logic signed [W-1:0]   xg3, yg3;

  always_comb begin
    mm2x = S3W'(mm2) <<< 1;
    d_c  = S3W'(qq2) + (S3W'(mm2) <<< 2);
    k_c  = (S3W'(pm02_2) <<< 1) - S3W'(pp2);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d3    <= DW'(d_c);
      kpd3  <= k_c + d_c;
      kmd3  <= k_c - d_c;
      sw3   <= S3W'(m12q2) + S3W'(m11dm2);
      sy3   <= S3W'(m11dn2) - S3W'(m21q2);
      tx3   <= S3W'(m02q2) - mm2x;
      ty3   <= -(S3W'(m20q2) + mm2x);
      m11p3 <= S3W'(m11p2);
      xg3   <= xg2;
      yg3   <= yg2;
    end
  end

  // first multiplier bank
  logic signed [G1W-1:0] pa1, pb1, pa2, pb2, px1, py1, px2, py2;

  mir_mul #(.AW(S3W), .BW(W), .LW(W)) u_mul_pa1 (
    .clk(clk), .en(adv), .a(m11p3), .b(plane_a), .p(pa1));
  mir_mul #(.AW(S3W), .BW(W), .LW(W)) u_mul_pb1 (
    .clk(clk), .en(adv), .a(kpd3), .b(plane_b), .p(pb1));
  mir_mul #(.AW(S3W), .BW(W), .LW(W)) u_mul_pa2 (
    .clk(clk), .en(adv), .a(kmd3), .b(plane_a), .p(pa2));
  mir_mul #(.AW(S3W), .BW(W), .LW(W)) u_mul_pb2 (
    .clk(clk), .en(adv), .a(m11p3), .b(plane_b), .p(pb2));
  mir_mul #(.AW(S3W), .BW(W), .LW(W)) u_mul_px1 (
    .clk(clk), .en(adv), .a(tx3), .b(xg3), .p(px1));
  mir_mul #(.AW(S3W), .BW(W), .LW(W)) u_mul_py1 (
    .clk(clk), .en(adv), .a(m11p3), .b(yg3), .p(py1));
  mir_mul #(.AW(S3W), .BW(W), .LW(W)) u_mul_px2 (
    .clk(clk), .en(adv), .a(m11p3), .b(xg3), .p(px2));
  mir_mul #(.AW(S3W), .BW(W), .LW(W)) u_mul_py2 (
    .clk(clk), .en(adv), .a(ty3), .b(yg3), .p(py2));

  // alignment delays
  logic signed [S3W-1:0] sw_pipe [L1];
  logic signed [S3W-1:0] sy_pipe [L1];
  logic [DW-1:0]         d_pipe  [DL];

  always_ff @(posedge clk) begin
    if (adv) begin
      sw_pipe[0] <= sw3;
      sy_pipe[0] <= sy3;
      d_pipe[0]  <= d3;
      for (int i = 1; i < L1; i++) begin
        sw_pipe[i] <= sw_pipe[i-1];
        sy_pipe[i] <= sy_pipe[i-1];
      end
      for (int i = 1; i < DL; i++) begin
        d_pipe[i] <= d_pipe[i-1];
      end
    end
  end

  // stage 5: numerators of vx, vy, wx, wy
  logic signed [NW-1:0] bt_x, bt_y, gs_x, gs_y;
  logic signed [NW-1:0] nvx5, nvy5, nwx5, nwy5;

  always_comb begin
    bt_x = NW'(sw_pipe[L1-1]) <<< 2;
    bt_y = NW'(sy_pipe[L1-1]) <<< 2;
    if (!discrete_mode) begin
      bt_x = bt_x + NW'(sw_pipe[L1-1]);
      bt_y = bt_y + NW'(sy_pipe[L1-1]);
    end
    bt_x = bt_x <<< F;
    bt_y = bt_y <<< F;
    gs_x = NW'(px1) + NW'(py1);
    gs_y = NW'(px2) + NW'(py2);
    if (discrete_mode) begin
      gs_x = gs_x <<< 1;
      gs_y = gs_y <<< 1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nvx5 <= (NW'(pa1) <<< 1) + NW'(pb1);
      nvy5 <= NW'(pa2) - (NW'(pb2) <<< 1);
      nwx5 <= bt_x + gs_x;
      nwy5 <= bt_y + gs_y;
    end
  end

  // second multiplier bank for vz
  logic signed [G2W-1:0] pzb, pza;

  mir_mul #(.AW(NW), .BW(W), .LW(W)) u_mul_zb (
    .clk(clk), .en(adv), .a(nwx5), .b(plane_b), .p(pzb));
  mir_mul #(.AW(NW), .BW(W), .LW(W)) u_mul_za (
    .clk(clk), .en(adv), .a(nwy5), .b(plane_a), .p(pza));

  logic signed [NW-1:0] nvx_pipe [L2];
  logic signed [NW-1:0] nvy_pipe [L2];
  logic signed [NW-1:0] nwx_pipe [L2];
  logic signed [NW-1:0] nwy_pipe [L2];

  always_ff @(posedge clk) begin
    if (adv) begin
      nvx_pipe[0] <= nvx5;
      nvy_pipe[0] <= nvy5;
      nwx_pipe[0] <= nwx5;
      nwy_pipe[0] <= nwy5;
      for (int i = 1; i < L2; i++) begin
        nvx_pipe[i] <= nvx_pipe[i-1];
        nvy_pipe[i] <= nvy_pipe[i-1];
        nwx_pipe[i] <= nwx_pipe[i-1];
        nwy_pipe[i] <= nwy_pipe[i-1];
      end
    end
  end

  // stage 7: all five numerators
  logic signed [NW-1:0] nvx7, nvy7, nwx7, nwy7;
  logic signed [ZW-1:0] nvz7;

  always_ff @(posedge clk) begin
    if (adv) begin
      nvx7 <= nvx_pipe[L2-1];
      nvy7 <= nvy_pipe[L2-1];
      nwx7 <= nwx_pipe[L2-1];
      nwy7 <= nwy_pipe[L2-1];
      nvz7 <= ZW'(pzb) - ZW'(pza);
    end
  end

  // dividers
  logic signed [W-1:0] vx_q, vy_q, vz_q, wx_q, wy_q;
  logic                vx_s, vy_s, vz_s, wx_s, wy_s;

  mir_div #(.NUM_W(NW), .DEN_W(DW), .NUM_SHIFT(imax(T_V, 0)),
            .DEN_SHIFT(imax(-T_V, 0)), .OUT_W(W)) u_div_vx (
    .clk(clk), .en(adv), .num(nvx7), .den(d_pipe[DL-1]), .val(vx_q), .sat(vx_s));
  mir_div #(.NUM_W(NW), .DEN_W(DW), .NUM_SHIFT(imax(T_V, 0)),
            .DEN_SHIFT(imax(-T_V, 0)), .OUT_W(W)) u_div_vy (
    .clk(clk), .en(adv), .num(nvy7), .den(d_pipe[DL-1]), .val(vy_q), .sat(vy_s));
  mir_div #(.NUM_W(ZW), .DEN_W(DW), .NUM_SHIFT(imax(T_Z, 0)),
            .DEN_SHIFT(imax(-T_Z, 0)), .OUT_W(W)) u_div_vz (
    .clk(clk), .en(adv), .num(nvz7), .den(d_pipe[DL-1]), .val(vz_q), .sat(vz_s));
  mir_div #(.NUM_W(NW), .DEN_W(DW), .NUM_SHIFT(imax(T_W, 0)),
            .DEN_SHIFT(imax(-T_W, 0)), .OUT_W(W)) u_div_wx (
    .clk(clk), .en(adv), .num(nwx7), .den(d_pipe[DL-1]), .val(wx_q), .sat(wx_s));
  mir_div #(.NUM_W(NW), .DEN_W(DW), .NUM_SHIFT(imax(T_W, 0)),
            .DEN_SHIFT(imax(-T_W, 0)), .OUT_W(W)) u_div_wy (
    .clk(clk), .en(adv), .num(nwy7), .den(d_pipe[DL-1]), .val(wy_q), .sat(wy_s));

  // degenerate flag follows the divider
  logic deg_pipe [QW+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      deg_pipe[0] <= (d_pipe[DL-1] == '0);
      for (int i = 1; i <= QW; i++) begin
        deg_pipe[i] <= deg_pipe[i-1];
      end
    end
  end

  // output register
  logic signed [W-1:0] row_vx, row_vy, row_vz, row_wx, row_wy;
  logic                degenerate, saturated;

  always_ff @(posedge clk) begin
    if (adv) begin
      degenerate <= deg_pipe[QW];
      if (deg_pipe[QW]) begin
        row_vx    <= '0;
        row_vy    <= '0;
        row_vz    <= '0;
        row_wx    <= '0;
        row_wy    <= '0;
        saturated <= 1'b0;
      end else begin
        row_vx    <= vx_q;
        row_vy    <= vy_q;
        row_vz    <= vz_q;
        row_wx    <= wx_q;
        row_wy    <= wy_q;
        saturated <= vx_s | vy_s | vz_s | wx_s | wy_s;
      end
    end
  end

  assign m_tdata = OUT_TDW'({row_wy, row_wx, row_vz, row_vy, row_vx});
  assign m_tuser = {saturated, degenerate};

  // checks
  `MIR_ASSERT_IMP(a_degenerate_clean, clk, rst, m_tvalid && m_tuser[0], m_tdata == '0 && !m_tuser[1])
  `MIR_ASSERT_NXT(a_stall_holds_chain, clk, rst, !adv, $stable(vld))

endmodule

`default_nettype wire

// ===== bench/tb_moment_orientation_interaction_row_unit.sv =====
// ---------------------------------------------------------------------------
// tb_moment_orientation_interaction_row_unit
// Streams moment sets through the orientation row unit under several plane
// and object-type settings, predicts each row with wide exact arithmetic (directed
// degenerate rows carry a typed answer) and compares every output transaction, in order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_moment_orientation_interaction_row_unit;
  import mir_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASE_ITEMS  = 200;
  localparam int N_PHASES     = 7;
  localparam int N_DIRECTED   = 12;
  localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S_MIN = 32'sh80000000;
  localparam logic signed [31:0] ONE_Q = 32'sh01000000;

  typedef logic signed [255:0] wide_t;

  // packed so that mu_11 lands in the lowest bits
  typedef struct packed {
    logic signed [31:0] cy, cx, m30, m03, m21, m12, m02, m20, m11;
  } moments_t;

  typedef struct packed {
    logic       sat, deg;
    logic [31:0] wy, wx, vz, vy, vx;
  } row_t;

  typedef struct packed {
    moments_t m;
    logic     typed;
    row_t     want;
  } dir_row_t;

  logic                  clk, rst;
  logic                  s_tvalid, s_tready;
  logic [287:0]          s_tdata;
  logic                  m_tvalid, m_tready;
  logic [159:0]          m_tdata;
  logic [1:0]            m_tuser;
  logic                  cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [31:0]           cfg_data;

  logic signed [31:0] plane_a_q, plane_b_q;
  logic               discrete_q;
  row_t               pending_rows[$];
  int                 errors;
  int                 tx_idle_pct, rx_idle_pct;
  int                 sent;
  dir_row_t           dir_tab[N_DIRECTED];

  moment_orientation_interaction_row_unit i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
    .m_tdata, .m_tuser, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [31:0] round_term(input wide_t n, input wide_t d, input int e,
                                             inout logic sat);
    wide_t mag, q, lim;
    logic  neg;
    int    t;
    neg = n < 0;
    mag = neg ? -n : n;
    t = OUT_FRAC_DEF + 1 - e;
    if (t >= 0) mag = mag <<< t;
    else d = d <<< (-t);
    q = (mag / d + 1) >>> 1;
    lim = wide_t'(1) <<< 31;
    if (!neg && q > lim - 1) begin
      q = lim - 1;
      sat = 1'b1;
    end else if (neg && q > lim) begin
      q = lim;
      sat = 1'b1;
    end
    if (neg) q = -q;
    return q[31:0];
  endfunction

  function automatic row_t predict_row(input moments_t m);
    wide_t m11, m20, m02, m12, m21, m03, m30, xg, yg, a, b;
    wide_t beta, gamma, sc, two, q, p, d, k, m11p, m11sq2, nvx, nvy, nwx, nwy, nvz;
    row_t  r;
    logic  sat;
    m11 = m.m11; m20 = m.m20; m02 = m.m02; m12 = m.m12; m21 = m.m21;
    m03 = m.m03; m30 = m.m30; xg = m.cx; yg = m.cy;
    a = plane_a_q; b = plane_b_q;
    two = 2;
    beta = discrete_q ? 4 : 5;
    gamma = discrete_q ? 2 : 1;
    sc = wide_t'(1) <<< IN_FRAC_DEF;
    r = '0;
    q = m20 - m02;
    p = m20 + m02;
    d = q * q + 4 * m11 * m11;
    if (d == 0) begin
      r.deg = 1'b1;
      return r;
    end
    m11p = m11 * p;
    m11sq2 = two * m11 * m11;
    k = two * p * m02 - p * p;
    nvx = two * m11p * a + (k + d) * b;
    nvy = (k - d) * a - two * b * m11p;
    nwx = beta * sc * (m12 * q + m11 * (m03 - m21)) + gamma * xg * (m02 * q - m11sq2)
          + gamma * yg * m11p;
    nwy = beta * sc * (m11 * (m30 - m12) - m21 * q) + gamma * xg * m11p
          - gamma * yg * (m20 * q + m11sq2);
    nvz = b * nwx - a * nwy;
    sat = 1'b0;
    r.vx = round_term(nvx, d, IN_FRAC_DEF + 1, sat);
    r.vy = round_term(nvy, d, IN_FRAC_DEF + 1, sat);
    r.vz = round_term(nvz, d, 2 * IN_FRAC_DEF, sat);
    r.wx = round_term(nwx, d, IN_FRAC_DEF, sat);
    r.wy = round_term(nwy, d, IN_FRAC_DEF, sat);
    r.sat = sat;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_field(input int kind);
    logic signed [31:0] v;
    v = $urandom;
    if (kind == 0) v = v >>> $urandom_range(4, 31);
    return v;
  endfunction

  function automatic moments_t rand_moments();
    moments_t m;
    int       sel, kind;
    sel = $urandom_range(99);
    kind = (sel < 25) ? 1 : 0;
    m.m11 = rand_field(kind); m.m20 = rand_field(kind); m.m02 = rand_field(kind);
    m.m12 = rand_field(kind); m.m21 = rand_field(kind); m.m03 = rand_field(kind);
    m.m30 = rand_field(kind); m.cx = rand_field(kind); m.cy = rand_field(kind);
    if (sel >= 88) begin
      m.m11 = '0;
      m.m02 = m.m20;
    end else if (sel >= 80) begin
      // tiny denominator, drives saturation
      m.m11 = '0;
      m.m02 = m.m20 - $signed($urandom_range(1, 3));
    end
    return m;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PLANE_A:  plane_a_q = val;
      REG_PLANE_B:  plane_b_q = val;
      REG_DISCRETE: discrete_q = val[0];
      default: ;
    endcase
  endtask

  task automatic send_item(input moments_t m, input logic typed, input row_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= m;
    do @(posedge clk); while (!s_tready);
    pending_rows.push_back(typed ? want : predict_row(m));
    sent++;
    tx_idle_pct = (sent < 470) ? 9 : (sent < 940) ? 81 : 0;
    rx_idle_pct = (sent < 470) ? 81 : (sent < 940) ? 9 : 0;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    row_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser[1], m_tuser[0], m_tdata};
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected transaction, actual %h", $time, got);
        errors++;
      end else begin
        want = pending_rows.pop_front();
        if (got !== want) begin
          $display("%0t: row mismatch, expected vx %h vy %h vz %h wx %h wy %h deg %b sat %b",
                   $time, want.vx, want.vy, want.vz, want.wx, want.wy, want.deg, want.sat);
          $display("%0t:               actual vx %h vy %h vz %h wx %h wy %h deg %b sat %b",
                   $time, got.vx, got.vy, got.vz, got.wx, got.wy, got.deg, got.sat);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t     deg_row;
    moments_t m;
    int       wait_cycles;
    errors = 0;
    sent = 0;
    tx_idle_pct = 9;
    rx_idle_pct = 81;
    plane_a_q = '0;
    plane_b_q = '0;
    discrete_q = 1'b1;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_PLANE_A;
    cfg_data = '0;
    deg_row = '0;
    deg_row.deg = 1'b1;

    // directed rows: degenerate ones carry their typed answer
    dir_tab[0] = '{'0, 1'b1, deg_row};
    m = '{default: S_MAX}; m.m11 = '0;
    dir_tab[1] = '{m, 1'b1, deg_row};
    m = '{default: S_MIN}; m.m11 = '0;
    dir_tab[2] = '{m, 1'b1, deg_row};
    m = '0; m.m20 = ONE_Q;
    dir_tab[3] = '{m, 1'b0, '0};
    m = '0; m.m11 = ONE_Q; m.m12 = ONE_Q; m.cx = ONE_Q; m.cy = -ONE_Q;
    dir_tab[4] = '{m, 1'b0, '0};
    m = '{default: S_MAX}; m.m02 = S_MIN;
    dir_tab[5] = '{m, 1'b0, '0};
    m = '{default: S_MIN}; m.m20 = S_MAX;
    dir_tab[6] = '{m, 1'b0, '0};
    m = '{default: S_MAX};
    dir_tab[7] = '{m, 1'b0, '0};
    m = '{default: S_MIN};
    dir_tab[8] = '{m, 1'b0, '0};
    m = '{default: S_MAX}; m.m11 = '0; m.m02 = S_MAX - 1;
    dir_tab[9] = '{m, 1'b0, '0};
    m = '0; m.m20 = 32'sd1; m.m12 = S_MIN; m.m30 = S_MAX;
    dir_tab[10] = '{m, 1'b0, '0};
    m = '{default: 32'sh55555555}; m.m11 = 32'shaaaaaaaa; m.cy = 32'shaaaaaaaa;
    dir_tab[11] = '{m, 1'b0, '0};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_item(dir_tab[i].m, dir_tab[i].typed, dir_tab[i].want);
    drain();
    write_reg(REG_PLANE_A, ONE_Q);
    write_reg(REG_PLANE_B, -ONE_Q);
    for (int i = 0; i < N_DIRECTED; i++)
      send_item(dir_tab[i].m, dir_tab[i].typed, dir_tab[i].want);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(REG_PLANE_A, S_MAX);
          write_reg(REG_PLANE_B, S_MIN);
          write_reg(REG_DISCRETE, 32'({$urandom, 1'b0}));
        end
        1: begin
          write_reg(REG_PLANE_A, S_MIN);
          write_reg(REG_PLANE_B, S_MAX);
          write_reg(REG_DISCRETE, 32'({$urandom, 1'b1}));
          write_reg(REG_UNUSED, $urandom);
        end
        2: begin
          write_reg(REG_PLANE_A, '0);
          write_reg(REG_PLANE_B, '0);
          write_reg(REG_DISCRETE, 32'd0);
        end
        default: begin
          write_reg(REG_PLANE_A, rand_field(0));
          write_reg(REG_PLANE_B, rand_field($urandom_range(1)));
          write_reg(REG_DISCRETE, $urandom);
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_item(rand_moments(), 1'b0, '0);
    end

    s_tvalid <= 1'b0;
    wait_cycles = 0;
    while (pending_rows.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_rows.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (pending_rows.size() != 0)
        $display("%0t: %0d expected rows never arrived", $time, pending_rows.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
